/* hw/rtl/sdti_pkg.sv */
`default_nettype none

package sdti_pkg;

	// Character codes and digit limits.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [3:0] DIGIT_LIMIT_MAX = 4'd9;
	localparam logic [3:0] COUNT_SAT = 4'd15;

	// Field widths.
	localparam int CHAR_W = 8;
	localparam int LIMIT_W = 4;
	localparam int COUNT_W = 4;
	localparam int ACC_W = 30;
	localparam int VALUE_W = 31;

	// One input request as held in the input register.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic last_char;
		logic empty_string;
	} item_t;

	// What the step logic hands to the result register.
	typedef struct packed {
		logic emit;
		logic parse_ok;
		logic signed [VALUE_W-1:0] value;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/sdti_core.sv */
`default_nettype none

module sdti_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step,
	input wire sdti_pkg::item_t item,
	input wire logic [sdti_pkg::LIMIT_W-1:0] limit,
	output sdti_pkg::result_t result
);

	logic [sdti_pkg::ACC_W-1:0] acc_q;
	logic [sdti_pkg::COUNT_W-1:0] count_q;
	logic neg_q;
	logic err_q;

	logic [sdti_pkg::ACC_W-1:0] acc_n;
	logic [sdti_pkg::COUNT_W-1:0] count_n;
	logic neg_n;
	logic err_n;
	logic first;
	logic numeral;
	logic [3:0] digit;
	logic [sdti_pkg::ACC_W-1:0] acc_x10;
	logic ok;
	logic [sdti_pkg::VALUE_W-1:0] mag;

	assign first = (count_q == '0) && !neg_q && !err_q;
	assign numeral = (item.character >= sdti_pkg::CH_ZERO)
		&& (item.character <= sdti_pkg::CH_NINE);
	// The digit codes start at 0x30, so the low nibble is the digit.
	assign digit = item.character[3:0];
	// Times ten as two shifted copies; the sum wraps at the accumulator width.
	assign acc_x10 = {acc_q[sdti_pkg::ACC_W-4:0], 3'b000}
		+ {acc_q[sdti_pkg::ACC_W-2:0], 1'b0};

	// Next string state for one character.
	always_comb begin
		acc_n = acc_q;
		count_n = count_q;
		neg_n = neg_q;
		err_n = err_q;
		if (first && (item.character == sdti_pkg::CH_MINUS)) begin
			neg_n = 1'b1;
		end else if (numeral) begin
			if (count_q != sdti_pkg::COUNT_SAT) begin
				count_n = count_q + 4'd1;
			end
			if (count_n > limit) begin
				err_n = 1'b1;
			end else if (!err_q) begin
				acc_n = acc_x10 + {{(sdti_pkg::ACC_W-4){1'b0}}, digit};
			end
		end else begin
			err_n = 1'b1;
		end
	end

	// Result at the end of a string or for an empty string.
	assign ok = !err_n && !(neg_n && (count_n == '0));
	assign mag = {1'b0, acc_n};

	always_comb begin
		result.emit = item.empty_string || item.last_char;
		result.parse_ok = 1'b1;
		result.value = '0;
		if (!item.empty_string) begin
			result.parse_ok = ok;
			if (ok) begin
				result.value = neg_n ? $signed(-mag) : $signed(mag);
			end
		end
	end

	// String state; it starts over after every result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			count_q <= '0;
			neg_q <= 1'b0;
			err_q <= 1'b0;
		end else if (step) begin
			if (result.emit) begin
				acc_q <= '0;
				count_q <= '0;
				neg_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				count_q <= count_n;
				neg_q <= neg_n;
				err_q <= err_n;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/signed_decimal_text_to_integer_top.sv */
`default_nettype none

// Parses a signed decimal string that arrives one character per request, with
// last_char on the final character, or as a single request with empty_string set.
// One request is taken every cycle while the input is not stalled; the accumulate
// step (multiply by ten plus the digit) is combinational between the input register
// and the result register, so a result passes through the input register and then
// the result register, which loads it once the output is not stalled. Results keep
// their order; a stalled result holds, and the input stalls only while a finished
// result is waiting behind it. max_digits is written through the cfg port (always
// ready) and values above nine act as nine; write it only while no string is in
// progress.

module signed_decimal_text_to_integer_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [sdti_pkg::LIMIT_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [sdti_pkg::CHAR_W-1:0] character,
	input wire logic last_char,
	input wire logic empty_string,
	output logic out_valid,
	input wire logic out_stall,
	output logic parse_ok,
	output logic signed [sdti_pkg::VALUE_W-1:0] value
);

	logic [sdti_pkg::LIMIT_W-1:0] max_digits_q;
	logic [sdti_pkg::LIMIT_W-1:0] limit;
	logic valid_s1;
	sdti_pkg::item_t item_s1;
	sdti_pkg::result_t result;
	logic out_valid_q;
	logic parse_ok_q;
	logic signed [sdti_pkg::VALUE_W-1:0] value_q;
	logic out_free;
	logic step;
	logic in_take;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_digits_q <= sdti_pkg::DIGIT_LIMIT_MAX;
		end else if (cfg_valid && cfg_ready) begin
			max_digits_q <= cfg_data;
		end
	end
	assign limit = (max_digits_q > sdti_pkg::DIGIT_LIMIT_MAX)
		? sdti_pkg::DIGIT_LIMIT_MAX : max_digits_q;

	// Handshake: the held request moves on unless its result cannot be stored.
	assign out_free = !out_valid_q || !out_stall;
	assign step = valid_s1 && (!result.emit || out_free);
	assign in_stall = valid_s1 && !step;
	assign in_take = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.character <= character;
			item_s1.last_char <= last_char;
			item_s1.empty_string <= empty_string;
		end
	end

	sdti_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.limit(limit),
		.result(result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && result.emit) begin
			parse_ok_q <= result.parse_ok;
			value_q <= result.value;
		end
	end

	assign out_valid = out_valid_q;
	assign parse_ok = parse_ok_q;
	assign value = value_q;

endmodule

`default_nettype wire

/* hw/rtl/sdti_checker.sv */
`default_nettype none

module sdti_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [sdti_pkg::LIMIT_W-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [sdti_pkg::CHAR_W-1:0] character,
	input wire logic last_char,
	input wire logic empty_string,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic parse_ok,
	input wire logic signed [sdti_pkg::VALUE_W-1:0] value
);

	// A stalled result stays and holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(parse_ok))
		else $error("stalled result changed");

	// A failed parse always reports zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !parse_ok |-> value == '0)
		else $error("failed parse with nonzero value");

	// Reported values never exceed nine digits.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value <= 31'sd999999999) && (value >= -31'sd999999999))
		else $error("value out of range");

	// The input stalls only behind a result that is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

endmodule

bind signed_decimal_text_to_integer_top sdti_checker u_sdti_checker (.*);

`default_nettype wire
